// ===== rtl/interval_seconds_converter_top_macros.svh =====
// assertion macros for the interval seconds converter
`ifndef INTERVAL_SECONDS_CONVERTER_TOP_MACROS_SVH
`define INTERVAL_SECONDS_CONVERTER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define ISC_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("interval converter check failed");
`define ISC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("interval converter check failed");
`else
`define ISC_ASSERT_IMPLY(label, ante, cons)
`define ISC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/isc_pkg.sv =====
// shared types, constants and tables of the interval seconds converter
`timescale 1ns / 1ps
`default_nettype none

package isc_pkg;

	localparam int SECS_PER_MIN    = 60;
	localparam int SECS_PER_HOUR   = 3600;
	localparam int SECS_PER_DAY    = 86400;
	localparam int SECS_PER_YEAR   = 365 * SECS_PER_DAY;
	localparam int HOURS_PER_DAY   = 24;
	localparam int MONTHS_PER_YEAR = 12;

	// floor(2^32 / divisor): the estimate is at most one below the true quotient
	localparam logic [31:0] RCP_MIN  = 32'((longint'(1) << 32) / SECS_PER_MIN);
	localparam logic [31:0] RCP_HOUR = 32'((longint'(1) << 32) / SECS_PER_HOUR);
	localparam logic [31:0] RCP_DAY  = 32'((longint'(1) << 32) / SECS_PER_DAY);
	localparam logic [31:0] RCP_YEAR = 32'((longint'(1) << 32) / SECS_PER_YEAR);
	localparam logic [31:0] RCP_HPD  = 32'((longint'(1) << 32) / HOURS_PER_DAY);
	localparam logic [31:0] RCP_MPY  = 32'((longint'(1) << 32) / MONTHS_PER_YEAR);

	// divider phases, counted down
	localparam logic [1:0] DIV_PH_EST = 2'd3;
	localparam logic [1:0] DIV_PH_REM = 2'd2;
	localparam logic [1:0] DIV_PH_FIX = 2'd1;

	localparam logic [1:0] STAGE_LAST = 2'd3;

	// division jobs: op bit on top, stage below
	typedef enum logic [2:0] {
		J_YR = 3'd0,
		J_DY = 3'd1,
		J_HR = 3'd2,
		J_MN = 3'd3,
		J_SE = 3'd4,
		J_MI = 3'd5,
		J_HN = 3'd6,
		J_MO = 3'd7
	} job_t;

	typedef enum logic [2:0] {
		T_YEAR = 3'd0,
		T_DAY  = 3'd1,
		T_HOUR = 3'd2,
		T_MIN  = 3'd3,
		T_SEC  = 3'd4
	} term_t;

	typedef struct packed {
		logic       load;
		logic       init;
		logic       step;
		logic       take;
		logic       mul;
		logic       acc;
		logic       fin;
		logic [1:0] stage;
		term_t      term;
	} isc_cmd_t;

	typedef struct packed {
		logic div_last;
		logic op;
	} isc_sts_t;

	function automatic logic [24:0] job_div(input job_t job);
		logic [24:0] d;
		case (job)
			J_YR:    d = 25'(SECS_PER_YEAR);
			J_DY:    d = 25'(SECS_PER_DAY);
			J_HR:    d = 25'(SECS_PER_HOUR);
			J_MN:    d = 25'(SECS_PER_MIN);
			J_SE:    d = 25'(SECS_PER_MIN);
			J_MI:    d = 25'(SECS_PER_MIN);
			J_HN:    d = 25'(HOURS_PER_DAY);
			J_MO:    d = 25'(MONTHS_PER_YEAR);
			default: d = 25'(MONTHS_PER_YEAR);
		endcase
		return d;
	endfunction

	function automatic logic [31:0] job_rcp(input job_t job);
		logic [31:0] r;
		case (job)
			J_YR:    r = RCP_YEAR;
			J_DY:    r = RCP_DAY;
			J_HR:    r = RCP_HOUR;
			J_MN:    r = RCP_MIN;
			J_SE:    r = RCP_MIN;
			J_MI:    r = RCP_MIN;
			J_HN:    r = RCP_HPD;
			J_MO:    r = RCP_MPY;
			default: r = RCP_MPY;
		endcase
		return r;
	endfunction

	// days in the first n months of a non-leap year
	function automatic logic [8:0] cum_days(input logic [3:0] n);
		logic [8:0] c;
		case (n)
			4'd0:    c = 9'd0;
			4'd1:    c = 9'd31;
			4'd2:    c = 9'd59;
			4'd3:    c = 9'd90;
			4'd4:    c = 9'd120;
			4'd5:    c = 9'd151;
			4'd6:    c = 9'd181;
			4'd7:    c = 9'd212;
			4'd8:    c = 9'd243;
			4'd9:    c = 9'd273;
			4'd10:   c = 9'd304;
			4'd11:   c = 9'd334;
			4'd12:   c = 9'd365;
			default: c = 9'd365;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/isc_ctrl.sv =====
// controller state machine of the interval seconds converter
`timescale 1ns / 1ps
`default_nettype none

module isc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            done,
	output isc_pkg::isc_cmd_t cmd,
	input  isc_pkg::isc_sts_t sts
);
	import isc_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_INIT = 7'b0000010,
		S_DIV  = 7'b0000100,
		S_TAKE = 7'b0001000,
		S_MUL  = 7'b0010000,
		S_ACC  = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] stage_q;
	term_t      term_q;
	logic       done_q;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.stage = stage_q;
		cmd.term  = term_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_INIT;
				end
			end
			S_INIT: begin
				cmd.init = 1'b1;
				state_d  = S_DIV;
			end
			S_DIV: begin
				cmd.step = 1'b1;
				if (sts.div_last) begin
					state_d = S_TAKE;
				end
			end
			S_TAKE: begin
				cmd.take = 1'b1;
				if (stage_q == STAGE_LAST) begin
					state_d = sts.op ? S_MUL : S_FIN;
				end else begin
					state_d = S_INIT;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				// product of the previous term lands in the accumulator
				cmd.acc = (term_q != T_YEAR);
				if (term_q == T_SEC) begin
					state_d = S_ACC;
				end
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stage_q <= '0;
			term_q  <= T_YEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_FIN);
			if (cmd.load) begin
				stage_q <= '0;
				term_q  <= T_YEAR;
			end else begin
				if (cmd.take && stage_q != STAGE_LAST) begin
					stage_q <= stage_q + 2'd1;
				end
				if (cmd.mul && term_q != T_SEC) begin
					term_q <= term_t'(term_q + 3'd1);
				end
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

`default_nettype wire

// ===== rtl/isc_datapath.sv =====
// datapath: shared reciprocal divider, month table, multiply-accumulate, result registers
`timescale 1ns / 1ps
`default_nettype none

module isc_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  isc_pkg::isc_cmd_t   cmd,
	output isc_pkg::isc_sts_t   sts,
	input  logic                op,
	input  logic signed [31:0]  total_seconds,
	input  logic signed [6:0]   years,
	input  logic signed [7:0]   months,
	input  logic signed [10:0]  days,
	input  logic signed [10:0]  hours,
	input  logic signed [14:0]  minutes,
	input  logic signed [17:0]  secs,
	output logic signed [7:0]   out_years,
	output logic signed [4:0]   out_months,
	output logic signed [5:0]   out_days,
	output logic signed [5:0]   out_hours,
	output logic signed [6:0]   out_minutes,
	output logic signed [6:0]   out_secs,
	output logic signed [32:0]  out_total
);
	import isc_pkg::*;

	// captured transaction
	logic               op_q;
	logic [31:0]        ts_q;
	logic signed [6:0]  yrs_in_q;
	logic signed [7:0]  mon_in_q;
	logic signed [10:0] day_in_q;
	logic signed [10:0] hr_in_q;
	logic signed [14:0] min_in_q;

	// divider
	logic [31:0] rem_q;
	logic [11:0] quo_q;
	logic [1:0]  cnt_q;
	logic        sgn_q;

	// op 0 magnitudes
	logic [6:0] yr_q;
	logic [8:0] dy_q;
	logic [4:0] hr_q;
	logic [5:0] mn_q, sc_q;

	// op 1 normalized fields
	logic signed [6:0]  se_q, mi_q;
	logic signed [5:0]  h_q;
	logic signed [4:0]  mo_q;
	logic signed [7:0]  y_q;
	logic signed [11:0] dsum_q;
	logic signed [17:0] nsum_q;

	logic signed [32:0] prod_s1, acc_q;

	logic signed [7:0]  out_years_q;
	logic signed [4:0]  out_months_q;
	logic signed [5:0]  out_days_q;
	logic signed [5:0]  out_hours_q;
	logic signed [6:0]  out_minutes_q;
	logic signed [6:0]  out_secs_q;
	logic signed [32:0] out_total_q;

	job_t               job;
	logic [31:0]        ts_mag;
	logic [17:0]        nsum_mag;
	logic [24:0]        dv;
	logic [63:0]        rcp_prod;
	logic [36:0]        qd_prod;
	logic               ge;
	logic signed [12:0] quo_ext, sq;
	logic signed [6:0]  rem_ext, sr;
	logic [4:0]         mo_abs;
	logic [8:0]         mcum;
	logic signed [12:0] mdays, dterm;
	logic signed [12:0] mul_a;
	logic [24:0]        mul_k;
	logic signed [38:0] prod_full;
	logic [3:0]         mcnt;
	logic [8:0]         dleft;
	logic               neg;

	assign job      = job_t'({op_q, cmd.stage});
	assign ts_mag   = ts_q[31] ? -ts_q : ts_q;
	assign nsum_mag = nsum_q[17] ? 18'(-nsum_q) : 18'(nsum_q);

	// quotient estimate by reciprocal, remainder, then at most one correction
	assign dv       = job_div(job);
	assign rcp_prod = rem_q * job_rcp(job);
	assign qd_prod  = quo_q * dv;
	assign ge       = (rem_q >= {7'b0, dv});

	// truncating division: quotient and remainder take the dividend's sign
	assign quo_ext = {1'b0, quo_q};
	assign sq      = sgn_q ? -quo_ext : quo_ext;
	assign rem_ext = {1'b0, rem_q[5:0]};
	assign sr      = sgn_q ? -rem_ext : rem_ext;

	assign mo_abs = mo_q[4] ? -mo_q : mo_q;
	assign mcum   = cum_days(mo_abs[3:0]);
	assign mdays  = mo_q[4] ? -{4'b0, mcum} : {4'b0, mcum};
	assign dterm  = {dsum_q[11], dsum_q} + mdays;

	always_comb begin
		case (cmd.term)
			T_YEAR: begin
				mul_a = {{5{y_q[7]}}, y_q};
				mul_k = 25'(SECS_PER_YEAR);
			end
			T_DAY: begin
				mul_a = dterm;
				mul_k = 25'(SECS_PER_DAY);
			end
			T_HOUR: begin
				mul_a = {{7{h_q[5]}}, h_q};
				mul_k = 25'(SECS_PER_HOUR);
			end
			T_MIN: begin
				mul_a = {{6{mi_q[6]}}, mi_q};
				mul_k = 25'(SECS_PER_MIN);
			end
			T_SEC: begin
				mul_a = {{6{se_q[6]}}, se_q};
				mul_k = 25'd1;
			end
			default: begin
				mul_a = '0;
				mul_k = '0;
			end
		endcase
	end

	assign prod_full = mul_a * $signed({1'b0, mul_k});

	// months fold out of the day count while it exceeds the next month length
	always_comb begin
		mcnt = '0;
		for (int k = 1; k < MONTHS_PER_YEAR; k++) begin
			if (dy_q > cum_days(4'(k))) begin
				mcnt = mcnt + 4'd1;
			end
		end
		dleft = dy_q - cum_days(mcnt);
	end

	assign neg = ts_q[31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.init) begin
			cnt_q <= DIV_PH_EST;
		end else if (cmd.step) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op;
			ts_q     <= total_seconds;
			yrs_in_q <= years;
			mon_in_q <= months;
			day_in_q <= days;
			hr_in_q  <= hours;
			min_in_q <= minutes;
			nsum_q   <= secs;
			acc_q    <= '0;
		end

		if (cmd.init) begin
			if (job == J_YR) begin
				rem_q <= ts_mag;
				sgn_q <= ts_q[31];
			end else if (op_q) begin
				rem_q <= {14'b0, nsum_mag};
				sgn_q <= nsum_q[17];
			end
			quo_q <= '0;
		end

		if (cmd.step) begin
			case (cnt_q)
				DIV_PH_EST: begin
					quo_q <= rcp_prod[43:32];
				end
				DIV_PH_REM: begin
					rem_q <= rem_q - qd_prod[31:0];
				end
				DIV_PH_FIX: begin
					if (ge) begin
						rem_q <= rem_q - {7'b0, dv};
						quo_q <= quo_q + 12'd1;
					end
				end
				default: begin
				end
			endcase
		end

		if (cmd.take) begin
			case (job)
				J_YR: yr_q <= quo_q[6:0];
				J_DY: dy_q <= quo_q[8:0];
				J_HR: hr_q <= quo_q[4:0];
				J_MN: begin
					mn_q <= quo_q[5:0];
					sc_q <= rem_q[5:0];
				end
				J_SE: begin
					se_q   <= sr;
					nsum_q <= {{3{min_in_q[14]}}, min_in_q} + {{5{sq[12]}}, sq};
				end
				J_MI: begin
					mi_q   <= sr;
					nsum_q <= {{7{hr_in_q[10]}}, hr_in_q} + {{5{sq[12]}}, sq};
				end
				J_HN: begin
					h_q    <= sr[5:0];
					dsum_q <= {day_in_q[10], day_in_q} + sq[11:0];
					nsum_q <= {{10{mon_in_q[7]}}, mon_in_q};
				end
				J_MO: begin
					mo_q <= sr[4:0];
					y_q  <= {yrs_in_q[6], yrs_in_q} + sq[7:0];
				end
				default: begin
					mo_q <= sr[4:0];
				end
			endcase
		end

		if (cmd.mul) begin
			prod_s1 <= prod_full[32:0];
		end
		if (cmd.acc) begin
			acc_q <= acc_q + prod_s1;
		end

		if (cmd.fin) begin
			if (op_q) begin
				out_years_q   <= '0;
				out_months_q  <= '0;
				out_days_q    <= '0;
				out_hours_q   <= '0;
				out_minutes_q <= '0;
				out_secs_q    <= '0;
				out_total_q   <= acc_q;
			end else begin
				out_years_q   <= neg ? -{1'b0, yr_q} : {1'b0, yr_q};
				out_months_q  <= neg ? -{1'b0, mcnt} : {1'b0, mcnt};
				out_days_q    <= neg ? -{1'b0, dleft[4:0]} : {1'b0, dleft[4:0]};
				out_hours_q   <= neg ? -{1'b0, hr_q} : {1'b0, hr_q};
				out_minutes_q <= neg ? -{1'b0, mn_q} : {1'b0, mn_q};
				out_secs_q    <= neg ? -{1'b0, sc_q} : {1'b0, sc_q};
				out_total_q   <= '0;
			end
		end
	end

	assign sts.div_last = (cnt_q == DIV_PH_FIX);
	assign sts.op       = op_q;

	assign out_years   = out_years_q;
	assign out_months  = out_months_q;
	assign out_days    = out_days_q;
	assign out_hours   = out_hours_q;
	assign out_minutes = out_minutes_q;
	assign out_secs    = out_secs_q;
	assign out_total   = out_total_q;

endmodule

`default_nettype wire

// ===== rtl/interval_seconds_converter_top.sv =====
// top level of the interval seconds converter
// one transaction at a time; start is taken again in the cycle done shows
// four constant divisions, each stepping through load, reciprocal estimate, remainder,
// correction and take, plus five multiply-accumulate steps for op 1; the receiver cannot stall
// arst_n clears the controller at once; result registers are not reset
`timescale 1ns / 1ps
`default_nettype none
`include "interval_seconds_converter_top_macros.svh"

module interval_seconds_converter_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  logic               op,
	input  logic signed [31:0] total_seconds,
	input  logic signed [6:0]  years,
	input  logic signed [7:0]  months,
	input  logic signed [10:0] days,
	input  logic signed [10:0] hours,
	input  logic signed [14:0] minutes,
	input  logic signed [17:0] secs,
	output logic signed [7:0]  out_years,
	output logic signed [4:0]  out_months,
	output logic signed [5:0]  out_days,
	output logic signed [5:0]  out_hours,
	output logic signed [6:0]  out_minutes,
	output logic signed [6:0]  out_secs,
	output logic signed [32:0] out_total
);
	import isc_pkg::*;

	isc_cmd_t cmd;
	isc_sts_t sts;
	logic     total_zero;
	logic     fields_zero;

	isc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	isc_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.op            (op),
		.total_seconds (total_seconds),
		.years         (years),
		.months        (months),
		.days          (days),
		.hours         (hours),
		.minutes       (minutes),
		.secs          (secs),
		.out_years     (out_years),
		.out_months    (out_months),
		.out_days      (out_days),
		.out_hours     (out_hours),
		.out_minutes   (out_minutes),
		.out_secs      (out_secs),
		.out_total     (out_total)
	);

	assign total_zero  = (out_total == '0);
	assign fields_zero = (out_years == '0) && (out_months == '0) && (out_days == '0)
		&& (out_hours == '0) && (out_minutes == '0) && (out_secs == '0);

	`ISC_ASSERT_IMPLY(a_done_idle, done, !busy)
	`ISC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`ISC_ASSERT_NEXT(a_done_single, done, !done)
	`ISC_ASSERT_IMPLY(a_one_side_zero, done, total_zero || fields_zero)

endmodule

`default_nettype wire

// ===== tb/sv/isc_tb_pkg.sv =====
// operation codes shared by the interval converter testbench files
`timescale 1ns / 1ps

package isc_tb_pkg;

	typedef enum logic {
		OP_SPLIT = 1'b0,
		OP_JOIN  = 1'b1
	} conv_op_t;

endpackage

// ===== tb/sv/isc_result_checker.sv =====
// checker that predicts and compares every interval converter transaction
`timescale 1ns / 1ps

module isc_result_checker
	import isc_pkg::*;
	import isc_tb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               done,
	input  logic               op,
	input  logic signed [31:0] total_seconds,
	input  logic signed [6:0]  years,
	input  logic signed [7:0]  months,
	input  logic signed [10:0] days,
	input  logic signed [10:0] hours,
	input  logic signed [14:0] minutes,
	input  logic signed [17:0] secs,
	input  logic signed [7:0]  out_years,
	input  logic signed [4:0]  out_months,
	input  logic signed [5:0]  out_days,
	input  logic signed [5:0]  out_hours,
	input  logic signed [6:0]  out_minutes,
	input  logic signed [6:0]  out_secs,
	input  logic signed [32:0] out_total,
	output int                 mismatches,
	output int                 outstanding
);

	localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	typedef struct {
		int unsigned        idx;
		logic signed [7:0]  yrs;
		logic signed [4:0]  mons;
		logic signed [5:0]  dys;
		logic signed [5:0]  hrs;
		logic signed [6:0]  mins;
		logic signed [6:0]  scs;
		logic signed [32:0] total;
	} interval_t;

	interval_t   pending_intervals [$];
	interval_t   want;
	int unsigned accepted;
	int unsigned cur_idx;

	function automatic interval_t convert_interval(
		input logic               op_i,
		input logic signed [31:0] ts,
		input logic signed [6:0]  y_i,
		input logic signed [7:0]  mo_i,
		input logic signed [10:0] d_i,
		input logic signed [10:0] h_i,
		input logic signed [14:0] mi_i,
		input logic signed [17:0] s_i
	);
		interval_t r;
		longint    t, yr, mo, dd, hr, mn, sc, mdays, tot;
		bit        neg;
		r.idx   = 0;
		r.yrs   = '0;
		r.mons  = '0;
		r.dys   = '0;
		r.hrs   = '0;
		r.mins  = '0;
		r.scs   = '0;
		r.total = '0;
		if (op_i == OP_SPLIT) begin
			neg = ts < 0;
			t   = neg ? -longint'(ts) : longint'(ts);
			yr  = t / SECS_PER_YEAR;
			t   = t % SECS_PER_YEAR;
			dd  = t / SECS_PER_DAY;
			t   = t % SECS_PER_DAY;
			mo  = 0;
			// a day count equal to the month length stays in days
			while (mo < 12 && dd > MONTH_DAYS[mo]) begin
				dd -= MONTH_DAYS[mo];
				mo++;
			end
			hr = t / SECS_PER_HOUR;
			t  = t % SECS_PER_HOUR;
			mn = t / SECS_PER_MIN;
			sc = t % SECS_PER_MIN;
			if (neg) begin
				yr = -yr; mo = -mo; dd = -dd; hr = -hr; mn = -mn; sc = -sc;
			end
			r.yrs  = 8'(yr);
			r.mons = 5'(mo);
			r.dys  = 6'(dd);
			r.hrs  = 6'(hr);
			r.mins = 7'(mn);
			r.scs  = 7'(sc);
		end else begin
			yr = y_i; mo = mo_i; dd = d_i; hr = h_i; mn = mi_i; sc = s_i;
			// truncating carries, remainders keep the sign of the dividend
			mn += sc / SECS_PER_MIN;     sc = sc % SECS_PER_MIN;
			hr += mn / SECS_PER_MIN;     mn = mn % SECS_PER_MIN;
			dd += hr / HOURS_PER_DAY;    hr = hr % HOURS_PER_DAY;
			yr += mo / MONTHS_PER_YEAR;  mo = mo % MONTHS_PER_YEAR;
			mdays = 0;
			for (int i = 0; i < 12; i++)
				if (i < (mo < 0 ? -mo : mo))
					mdays += MONTH_DAYS[i];
			if (mo < 0)
				mdays = -mdays;
			tot = yr * SECS_PER_YEAR + mdays * SECS_PER_DAY + dd * SECS_PER_DAY
				+ hr * SECS_PER_HOUR + mn * SECS_PER_MIN + sc;
			r.total = 33'(tot);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic signed [32:0] got,
			input logic signed [32:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("transaction %0d %s: got %0d, expected %0d",
				cur_idx, name, got, exp_val));
	endtask

	initial begin
		mismatches  = 0;
		outstanding = 0;
		accepted    = 0;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			pending_intervals.delete();
		end else begin
			// a done and a new transaction may share one edge: retire first
			if (done) begin
				if (pending_intervals.size() == 0) begin
					report_mismatch("done with no transaction outstanding");
				end else begin
					want    = pending_intervals.pop_front();
					cur_idx = want.idx;
					check_field("out_years",   out_years,   want.yrs);
					check_field("out_months",  out_months,  want.mons);
					check_field("out_days",    out_days,    want.dys);
					check_field("out_hours",   out_hours,   want.hrs);
					check_field("out_minutes", out_minutes, want.mins);
					check_field("out_secs",    out_secs,    want.scs);
					check_field("out_total",   out_total,   want.total);
				end
			end
			if (start && !busy) begin
				want = convert_interval(op, total_seconds, years, months, days, hours,
					minutes, secs);
				want.idx = accepted;
				accepted++;
				pending_intervals.push_back(want);
			end
		end
		outstanding = pending_intervals.size();
	end

endmodule

// ===== tb/sv/tb_interval_seconds_converter_top.sv =====
// testbench top: stimulus, pacing and verdict for the interval seconds converter
`timescale 1ns / 1ps

module tb_interval_seconds_converter_top;
	import isc_pkg::*;
	import isc_tb_pkg::*;

	localparam int RANDOM_ITEMS = 700;
	localparam int DRAIN_CYCLES = 60;
	// last day of each month counted from the start of the year
	localparam int MONTH_ENDS [12] = '{31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
	localparam logic signed [31:0] EDGE_SECONDS [18] = '{
		32'sd0, 32'sd1, -32'sd1, 32'sd59, 32'sd60, 32'sd3599, 32'sd86399, 32'sd86400,
		32'sd2678400,    // exactly 31 days, stays in days
		32'sd2764801,    // 32 days and one second
		32'sd5097600,    // 59 days, february full
		32'sd31535999,   // last second of a year
		32'sd31536000, -32'sd31536001,
		32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0001, -32'sd2764801
	};

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               done;
	logic               op;
	logic signed [31:0] total_seconds;
	logic signed [6:0]  years;
	logic signed [7:0]  months;
	logic signed [10:0] days;
	logic signed [10:0] hours;
	logic signed [14:0] minutes;
	logic signed [17:0] secs;
	logic signed [7:0]  out_years;
	logic signed [4:0]  out_months;
	logic signed [5:0]  out_days;
	logic signed [5:0]  out_hours;
	logic signed [6:0]  out_minutes;
	logic signed [6:0]  out_secs;
	logic signed [32:0] out_total;
	int                 mismatches;
	int                 outstanding;
	int                 burst_left;

	interval_seconds_converter_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.done          (done),
		.op            (op),
		.total_seconds (total_seconds),
		.years         (years),
		.months        (months),
		.days          (days),
		.hours         (hours),
		.minutes       (minutes),
		.secs          (secs),
		.out_years     (out_years),
		.out_months    (out_months),
		.out_days      (out_days),
		.out_hours     (out_hours),
		.out_minutes   (out_minutes),
		.out_secs      (out_secs),
		.out_total     (out_total)
	);

	isc_result_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.done          (done),
		.op            (op),
		.total_seconds (total_seconds),
		.years         (years),
		.months        (months),
		.days          (days),
		.hours         (hours),
		.minutes       (minutes),
		.secs          (secs),
		.out_years     (out_years),
		.out_months    (out_months),
		.out_days      (out_days),
		.out_hours     (out_hours),
		.out_minutes   (out_minutes),
		.out_secs      (out_secs),
		.out_total     (out_total),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int span(input int lo, input int hi);
		return int'($urandom_range(hi - lo)) + lo;
	endfunction

	// present one transaction at the falling edge and hold it until taken
	task automatic drive_conv(input conv_op_t op_i, input logic signed [31:0] ts,
			input logic signed [6:0] y_i, input logic signed [7:0] mo_i,
			input logic signed [10:0] d_i, input logic signed [10:0] h_i,
			input logic signed [14:0] mi_i, input logic signed [17:0] s_i);
		@(negedge clk);
		start         <= 1'b1;
		op            <= op_i;
		total_seconds <= ts;
		years         <= y_i;
		months        <= mo_i;
		days          <= d_i;
		hours         <= h_i;
		minutes       <= mi_i;
		secs          <= s_i;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
	endtask

	// unused fields carry junk, the block must ignore them
	task automatic send_split(input logic signed [31:0] ts);
		drive_conv(OP_SPLIT, ts, 7'($urandom), 8'($urandom), 11'($urandom),
			11'($urandom), 15'($urandom), 18'($urandom));
	endtask

	task automatic send_join(input logic signed [6:0] y_i, input logic signed [7:0] mo_i,
			input logic signed [10:0] d_i, input logic signed [10:0] h_i,
			input logic signed [14:0] mi_i, input logic signed [17:0] s_i);
		drive_conv(OP_JOIN, 32'($urandom), y_i, mo_i, d_i, h_i, mi_i, s_i);
	endtask

	// bursts of back-to-back requests separated by random idle gaps
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap        = ($urandom_range(3) == 0) ? span(1, 120) : span(0, 40);
			burst_left = ($urandom_range(4) == 0) ? span(15, 40) : span(0, 5);
			if (gap > 0) begin
				@(negedge clk);
				start <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	task automatic random_split();
		longint mag;
		int     dd;
		case ($urandom_range(3))
			0: mag = longint'($urandom) - 64'sd2147483648;
			1: begin
				dd  = MONTH_ENDS[$urandom_range(11)] + span(-1, 1);
				if (dd > 364)
					dd = 364;
				mag = longint'(span(0, 67)) * SECS_PER_YEAR + longint'(dd) * SECS_PER_DAY
					+ (($urandom_range(1) == 0) ? 0 : span(0, SECS_PER_DAY - 1));
			end
			2: mag = longint'(span(0, 67)) * SECS_PER_YEAR
				+ longint'(span(0, 364)) * SECS_PER_DAY + span(0, SECS_PER_DAY - 1);
			default: mag = span(0, 2 * SECS_PER_DAY);
		endcase
		if ($urandom_range(1) == 1)
			mag = -mag;
		send_split(32'(mag));
	endtask

	task automatic random_join();
		if ($urandom_range(1) == 0)
			send_join(7'($urandom), 8'($urandom), 11'($urandom), 11'($urandom),
				15'($urandom), 18'($urandom));
		else
			send_join(7'(span(-60, 60)), 8'(span(-96, 96)), 11'(span(-1000, 1000)),
				11'(span(-1000, 1000)), 15'(span(-10000, 10000)),
				18'(span(-100000, 100000)));
	endtask

	initial begin
		arst_n        <= 1'b0;
		start         <= 1'b0;
		op            <= OP_SPLIT;
		total_seconds <= '0;
		years         <= '0;
		months        <= '0;
		days          <= '0;
		hours         <= '0;
		minutes       <= '0;
		secs          <= '0;
		burst_left     = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		foreach (EDGE_SECONDS[i]) begin
			send_split(EDGE_SECONDS[i]);
			pace_sender();
		end
		send_join('0, '0, '0, '0, '0, '0);
		send_join(7'sd63, 8'sd127, 11'sd1023, 11'sd1023, 15'sd16383, 18'sd131071);
		// most negative value of every field
		send_join(7'sh40, 8'sh80, 11'sh400, 11'sh400, 15'sh4000, 18'sh20000);
		send_join(7'sd0, -8'sd1, 11'sd0, 11'sd0, 15'sd0, -18'sd61);
		send_join(-7'sd60, 8'sd12, -11'sd1, 11'sd23, -15'sd59, 18'sd59);
		send_join(7'sd60, -8'sd13, 11'sd1000, -11'sd1000, 15'sd10000, -18'sd100000);

		repeat (RANDOM_ITEMS) begin
			if ($urandom_range(1) == 0)
				random_split();
			else
				random_join();
			pace_sender();
		end

		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("** interval_seconds_converter_top: PASSED **");
		else
			$display("** interval_seconds_converter_top: FAILED **");
		$finish;
	end

	initial begin
		#20ms;
		$display("** interval_seconds_converter_top: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/isc_pkg.sv
rtl/isc_ctrl.sv
rtl/isc_datapath.sv
rtl/interval_seconds_converter_top.sv
tb/sv/isc_tb_pkg.sv
tb/sv/isc_result_checker.sv
tb/sv/tb_interval_seconds_converter_top.sv
